// ===== rtl/gcl_pkg.sv =====
// ----------------------------------------------------------------------------
// gcl_pkg: shared widths and codes of the gene convergence lock unit
// Field widths, stream packing sizes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

  localparam int unsigned GENES      = 1024;
  localparam int unsigned GENE_W     = $clog2(GENES);
  localparam int unsigned LABEL_W    = 3;
  localparam int unsigned CLUSTERS   = 8;
  localparam int unsigned CL_W       = $clog2(CLUSTERS);
  localparam int unsigned FEATURES   = 4;
  localparam int unsigned FEAT_W     = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned STAB_W     = 16;
  localparam int unsigned LOCK_W     = 4;
  localparam int unsigned CNT_W      = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Gene table entry: {locked label, stability}
  localparam int unsigned ENTRY_W    = LOCK_W + STAB_W;

  // Input stream: tdata {f3, f2, f1, f0, label_b, label_a, gene_index}
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned IU_FIRST   = 0;
  localparam int unsigned IU_GSTART  = 1;

  // Output stream: tdata {pad, sum_3..sum_0, members, locks, label, stability, gene}
  localparam int unsigned OUT_DATA_W = 184;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned OU_SKIPPED = 0;
  localparam int unsigned OU_AGREED  = 1;
  localparam int unsigned OU_NEWLY   = 2;

  // Configuration registers
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_LIMIT   = 1'd1;

  localparam logic [STAB_W-1:0] STABLE_LIMIT_RST = 16'd1;
  localparam logic [CNT_W-1:0]  LOCK_LIMIT_RST   = 11'd1024;

endpackage

`default_nettype wire

// ===== rtl/gene_convergence_lock_unit.sv =====
// ----------------------------------------------------------------------------
// gene_convergence_lock_unit: per-gene convergence lock for genetic clustering
// Tracks pair agreement per gene, counts stable generations, locks genes to a
// cluster and accumulates the locked genes' features into cluster sums.
// ----------------------------------------------------------------------------
// Dataflow: the gene table is read at accept; stage 1 decides, and a last-pair
//   result is loaded into the output register once that register is free.
// Throughput: one request per cycle while no last-pair result is held back by
//   a stalled output; the gene table has one read and one write port, and a
//   one-entry bypass covers back-to-back requests on one gene.
// Reset: control state, counters, cluster sums and configuration registers
//   return to their defaults at once; then a pass clears every gene table
//   entry, keeping s_axis_tready_o low. Configuration writes are taken throughout.
`default_nettype none

module gene_convergence_lock_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [gcl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gcl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata, low bit up: gene_index, label_a, label_b, feature_0..feature_3
  input  wire logic [gcl_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser, low bit up: first_pair, generation_start
  input  wire logic [gcl_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  input  wire logic                           s_axis_tlast_i,   // last_pair
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata, low bit up: gene_out, stability, locked_label, locks_total,
  // cluster_members, sum_0..sum_3, zero pad
  output logic      [gcl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser, low bit up: skipped, all_agreed, newly_locked
  output logic      [gcl_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  import gcl_pkg::*;

  localparam int unsigned OUT_USED_W = GENE_W + STAB_W + LOCK_W + 2 * CNT_W + FEATURES * SUM_W;

  // Saturating add of a Q8.8 feature into a 32-bit sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [FEAT_W-1:0] f);
    logic [SUM_W:0] s;
    begin
      s = {a[SUM_W-1], a} + {{(SUM_W - FEAT_W + 1){f[FEAT_W-1]}}, f};
      if (s[SUM_W] != s[SUM_W-1]) begin
        sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sat_add = s[SUM_W-1:0];
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [STAB_W-1:0] stable_limit_q;
  logic [CNT_W-1:0]  lock_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_limit_q <= STABLE_LIMIT_RST;
      lock_limit_q   <= LOCK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STABLE_LIMIT: stable_limit_q <= cfg_wdata_i[STAB_W-1:0];
        REG_LOCK_LIMIT:   lock_limit_q   <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Gene table clearing pass after reset
  // --------------------------------------------------------------------------
  logic [GENE_W:0] clr_cnt_q;
  logic            clearing;

  assign clearing = !clr_cnt_q[GENE_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and stage 1 (decision stage)
  // --------------------------------------------------------------------------
  logic                 s1_vld_q;
  logic [IN_DATA_W-1:0] s1_data_q;
  logic [IN_USER_W-1:0] s1_user_q;
  logic                 s1_last_q;

  logic out_vld_q;
  logic out_free;
  logic s1_fire;
  logic s_fire;
  logic res_load;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s1_fire         = s1_vld_q && (!s1_last_q || out_free);
  assign res_load        = s1_fire && s1_last_q;
  assign s_axis_tready_o = !clearing && (!s1_vld_q || s1_fire);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_data_q <= s_axis_tdata_i;
      s1_user_q <= s_axis_tuser_i;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  // Unpack the held request
  logic [GENE_W-1:0]  s1_gene;
  logic [LABEL_W-1:0] s1_label_a;
  logic [LABEL_W-1:0] s1_label_b;
  logic [FEAT_W-1:0]  s1_feat [FEATURES];

  assign s1_gene    = s1_data_q[GENE_W-1:0];
  assign s1_label_a = s1_data_q[GENE_W +: LABEL_W];
  assign s1_label_b = s1_data_q[GENE_W + LABEL_W +: LABEL_W];

  for (genvar k = 0; k < FEATURES; k++) begin : g_feat
    assign s1_feat[k] = s1_data_q[GENE_W + 2 * LABEL_W + k * FEAT_W +: FEAT_W];
  end

  // --------------------------------------------------------------------------
  // Gene table: {locked label, stability}, read at accept, written on decision
  // --------------------------------------------------------------------------
  logic               mem_we;
  logic [GENE_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [ENTRY_W-1:0] dec_entry;

  assign mem_we    = clearing || res_load;
  assign mem_waddr = clearing ? clr_cnt_q[GENE_W-1:0] : s1_gene;
  assign mem_wdata = clearing ? '0 : dec_entry;

  gcl_ram #(
    .AW (GENE_W),
    .DW (ENTRY_W)
  ) u_gene_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (s_fire),
    .raddr_i (s_axis_tdata_i[GENE_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // Bypass: the read issued in the cycle of the last write misses that write
  logic               fwd_vld_q;
  logic [GENE_W-1:0]  fwd_addr_q;
  logic [ENTRY_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else if (res_load) begin
      fwd_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      fwd_addr_q <= s1_gene;
      fwd_data_q <= dec_entry;
    end
  end

  logic [ENTRY_W-1:0] rd_entry;
  logic [STAB_W-1:0]  rd_stab;
  logic [LOCK_W-1:0]  rd_lock;

  assign rd_entry = (fwd_vld_q && fwd_addr_q == s1_gene) ? fwd_data_q : mem_rdata;
  assign rd_stab  = rd_entry[STAB_W-1:0];
  assign rd_lock  = rd_entry[STAB_W +: LOCK_W];

  // --------------------------------------------------------------------------
  // Pair tracking and generation gate
  // --------------------------------------------------------------------------
  logic               agree_q;
  logic [LABEL_W-1:0] first_label_q;
  logic               gen_open_q;
  logic [CNT_W-1:0]   lock_count_q;

  logic               agree_d;
  logic [LABEL_W-1:0] first_label_d;
  logic               gen_open_d;

  assign agree_d       = (s1_user_q[IU_FIRST] || agree_q) && (s1_label_a == s1_label_b);
  assign first_label_d = s1_user_q[IU_FIRST] ? s1_label_a : first_label_q;
  assign gen_open_d    = s1_user_q[IU_GSTART] ? !(lock_count_q > lock_limit_q) : gen_open_q;

  // --------------------------------------------------------------------------
  // Decision
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]  member_q [CLUSTERS];
  logic [SUM_W-1:0]  sum_q    [CLUSTERS][FEATURES];

  logic              agreed;
  logic [STAB_W-1:0] stab_inc;
  logic              newly;
  logic [STAB_W-1:0] stab_new;
  logic [LOCK_W-1:0] lock_new;
  logic [CNT_W-1:0]  lock_count_d;
  logic [CL_W-1:0]   cl_sel;
  logic [CNT_W-1:0]  member_new;
  logic [SUM_W-1:0]  sum_new  [FEATURES];

  assign agreed   = gen_open_d && agree_d;
  assign stab_inc = (rd_stab == {STAB_W{1'b1}}) ? rd_stab : rd_stab + 1'b1;
  assign newly    = agreed && (stab_inc >= stable_limit_q) && (rd_lock == '0);
  assign stab_new = !gen_open_d ? rd_stab : (agreed ? stab_inc : '0);
  assign lock_new = newly ? LOCK_W'(first_label_d[CL_W-1:0]) + 1'b1 : rd_lock;

  assign dec_entry = {lock_new, stab_new};

  assign lock_count_d = (newly && lock_count_q != CNT_MAX) ? lock_count_q + 1'b1
                                                           : lock_count_q;

  // One cluster feeds the result: the new lock's, else the stored lock's
  assign cl_sel = newly ? first_label_d[CL_W-1:0] : CL_W'(rd_lock - 1'b1);

  assign member_new = (newly && member_q[cl_sel] != CNT_MAX) ? member_q[cl_sel] + 1'b1
                                                             : member_q[cl_sel];

  for (genvar k = 0; k < FEATURES; k++) begin : g_sum
    assign sum_new[k] = newly ? sat_add(sum_q[cl_sel][k], s1_feat[k]) : sum_q[cl_sel][k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agree_q       <= 1'b1;
      first_label_q <= '0;
      gen_open_q    <= 1'b1;
    end else if (s1_fire) begin
      agree_q       <= s1_last_q ? 1'b1 : agree_d;
      first_label_q <= first_label_d;
      gen_open_q    <= gen_open_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_count_q <= '0;
      for (int c = 0; c < CLUSTERS; c++) begin
        member_q[c] <= '0;
        for (int k = 0; k < FEATURES; k++) begin
          sum_q[c][k] <= '0;
        end
      end
    end else if (res_load && newly) begin
      lock_count_q     <= lock_count_d;
      member_q[cl_sel] <= member_new;
      for (int k = 0; k < FEATURES; k++) begin
        sum_q[cl_sel][k] <= sum_new[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_USER_W-1:0] res_user;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;
  logic                  has_lock;

  assign has_lock = (lock_new != '0);

  always_comb begin
    res_data = '0;
    res_data[GENE_W-1:0]                                = s1_gene;
    res_data[GENE_W +: STAB_W]                          = stab_new;
    res_data[GENE_W + STAB_W +: LOCK_W]                 = lock_new;
    res_data[GENE_W + STAB_W + LOCK_W +: CNT_W]         = lock_count_d;
    res_data[GENE_W + STAB_W + LOCK_W + CNT_W +: CNT_W] = has_lock ? member_new : '0;
    for (int k = 0; k < FEATURES; k++) begin
      res_data[OUT_USED_W - (FEATURES - k) * SUM_W +: SUM_W] = has_lock ? sum_new[k] : '0;
    end
    res_user             = '0;
    res_user[OU_SKIPPED] = !gen_open_d;
    res_user[OU_AGREED]  = agreed;
    res_user[OU_NEWLY]   = newly;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

// ===== rtl/gcl_ram.sv =====
// ----------------------------------------------------------------------------
// gcl_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_ram #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 20
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gcl_checker.sv =====
// ----------------------------------------------------------------------------
// gcl_checker: port-level checks of the gene convergence lock unit
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tready_o,
  input  wire logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  input  wire logic [gcl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  wire logic [gcl_pkg::OUT_USER_W-1:0] m_axis_tuser_o
);

  import gcl_pkg::*;

  localparam int unsigned LBL_LO = GENE_W + STAB_W;
  localparam int unsigned MEM_LO = GENE_W + STAB_W + LOCK_W + CNT_W;
  localparam int unsigned SUM_LO = MEM_LO + CNT_W;

  logic [LOCK_W-1:0] lbl;
  logic [CNT_W-1:0]  members;
  logic [SUM_W-1:0]  sum0;

  assign lbl     = m_axis_tdata_o[LBL_LO +: LOCK_W];
  assign members = m_axis_tdata_o[MEM_LO +: CNT_W];
  assign sum0    = m_axis_tdata_o[SUM_LO +: SUM_W];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // The gene table clear keeps the request side closed right after reset
  a_clear_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("request accepted during table clear");

  // A gated generation neither agrees nor locks
  a_skip_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[OU_SKIPPED] |->
      !m_axis_tuser_o[OU_AGREED] && !m_axis_tuser_o[OU_NEWLY])
    else $error("skipped result shows agreement or lock");

  // A fresh lock names a cluster that now has members
  a_new_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[OU_NEWLY] |->
      m_axis_tuser_o[OU_AGREED] && lbl != '0 && members != '0)
    else $error("new lock without label or members");

  // An unlocked gene reports an empty cluster
  a_unlocked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && lbl == '0 |-> members == '0 && sum0 == '0)
    else $error("unlocked gene reports cluster data");

endmodule

bind gene_convergence_lock_unit gcl_checker u_gcl_checker (.*);

`default_nettype wire
